// ----- src/mlqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types, codes and defaults for the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  localparam int ID_BITS             = 8;
  localparam int NUM_LEVELS          = 4;
  localparam int LEVEL_DEPTH_DEF     = 16;
  localparam int STAGING_DEPTH_DEF   = 32;
  localparam int LIMIT_W             = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [2:0] PRIO_MAX    = 3'd7;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] ST_ADDED      = 2'd0;
  localparam logic [1:0] ST_DROPPED    = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  localparam logic [1:0] LV_RT = 2'd0;
  localparam logic [1:0] LV_U1 = 2'd1;
  localparam logic [1:0] LV_U2 = 2'd2;
  localparam logic [1:0] LV_U3 = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [ID_BITS-1:0] task_id;
    logic               task_realtime;
    logic [2:0]         task_priority;
    logic               demote;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] out_task_id;
    logic               out_realtime;
    logic [2:0]         out_priority;
  } out_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic               rt;
    logic [2:0]         prio;
  } entry_t;

  typedef struct packed {
    logic accept_add;
    logic accept_disp;
    logic drain_rd;
    logic drain_wr;
    logic pop_rd;
    logic pop_done;
  } cmd_t;

  typedef struct packed {
    logic stg_empty;
    logic drain_last;
    logic any_level;
    logic out_blocked;
  } sts_t;

endpackage

// ----- src/mlqs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_ctrl
// Sequencer: accepts items, walks the staging drain, then the level pop.
// ----------------------------------------------------------------------------
module mlqs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            opcode,
  input  mlqs_pkg::sts_t  sts,
  output logic            in_stall,
  output mlqs_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DRAIN_RD = 5'b00010,
    S_DRAIN_WR = 5'b00100,
    S_POP_RD   = 5'b01000,
    S_POP_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || sts.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.accept_add  = accept && (opcode == mlqs_pkg::OP_ADD);
    cmd.accept_disp = accept && (opcode == mlqs_pkg::OP_DISPATCH);
    cmd.drain_rd    = (state == S_DRAIN_RD);
    cmd.drain_wr    = (state == S_DRAIN_WR);
    cmd.pop_rd      = (state == S_POP_RD);
    cmd.pop_done    = (state == S_POP_DONE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept_disp) begin
          state_next = sts.stg_empty ? S_POP_RD : S_DRAIN_RD;
        end
      end
      S_DRAIN_RD: state_next = S_DRAIN_WR;
      S_DRAIN_WR: state_next = sts.drain_last ? S_POP_RD : S_DRAIN_RD;
      S_POP_RD:   state_next = sts.any_level ? S_POP_DONE : S_IDLE;
      S_POP_DONE: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/mlqs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_dp
// Datapath: staging FIFO, level FIFO memory, limit register, result register.
// ----------------------------------------------------------------------------
module mlqs_dp #(
  parameter int LEVEL_DEPTH   = mlqs_pkg::LEVEL_DEPTH_DEF,
  parameter int STAGING_DEPTH = mlqs_pkg::STAGING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlqs_pkg::cmd_t                cmd,
  input  mlqs_pkg::in_t                 in_data,
  input  logic                          cfg_we,
  input  logic [mlqs_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                          out_stall,
  output logic                          out_valid,
  output mlqs_pkg::out_t                out_data,
  output mlqs_pkg::sts_t                sts
);

  localparam int SI_W   = $clog2(STAGING_DEPTH);
  localparam int SC_W   = $clog2(STAGING_DEPTH + 1);
  localparam int LI_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int LC_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int CMP_W  = (LC_W > mlqs_pkg::LIMIT_W) ? LC_W : mlqs_pkg::LIMIT_W;
  localparam int NL     = mlqs_pkg::NUM_LEVELS;
  localparam int LMEM_N = NL * (1 << LI_W);

  mlqs_pkg::entry_t stg_mem [STAGING_DEPTH];
  mlqs_pkg::entry_t lvl_mem [LMEM_N];

  logic [SI_W-1:0]             stg_head;
  logic [SC_W-1:0]             stg_count;
  logic [SC_W-1:0]             drain_left;
  mlqs_pkg::entry_t            stg_rd;
  mlqs_pkg::entry_t            lvl_rd;
  logic [LI_W-1:0]             lvl_head  [NL];
  logic [LC_W-1:0]             lvl_count [NL];
  logic [mlqs_pkg::LIMIT_W-1:0] limit;
  mlqs_pkg::out_t              out_reg;

  logic [SI_W-1:0]  stg_tail;
  logic [SC_W:0]    stg_sum;
  logic [SI_W-1:0]  stg_head_inc;
  logic             stg_full;
  logic [LI_W-1:0]  lvl_tail [NL];
  logic [LC_W:0]    lvl_sum  [NL];
  logic [NL-1:0]    room;
  logic [NL-1:0]    nonempty;
  logic             place_ok;
  logic [1:0]       place_lv;
  logic [1:0]       pop_sel;
  logic [2:0]       new_prio;
  mlqs_pkg::entry_t new_entry;
  mlqs_pkg::entry_t stg_wr_data;
  logic             stg_we;

  // staging tail = head + count, wrapped once
  always_comb begin
    stg_sum = (SC_W + 1)'(stg_head) + (SC_W + 1)'(stg_count);
    if (stg_sum >= (SC_W + 1)'(STAGING_DEPTH)) begin
      stg_sum = stg_sum - (SC_W + 1)'(STAGING_DEPTH);
    end
    stg_tail = stg_sum[SI_W-1:0];
  end

  assign stg_head_inc = (stg_head == SI_W'(STAGING_DEPTH - 1)) ? '0 : stg_head + 1'b1;
  assign stg_full     = (stg_count == SC_W'(STAGING_DEPTH));

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lvl_sum[l] = (LC_W + 1)'(lvl_head[l]) + (LC_W + 1)'(lvl_count[l]);
      if (lvl_sum[l] >= (LC_W + 1)'(LEVEL_DEPTH)) begin
        lvl_sum[l] = lvl_sum[l] - (LC_W + 1)'(LEVEL_DEPTH);
      end
      lvl_tail[l] = lvl_sum[l][LI_W-1:0];
      // count never exceeds depth, so this also caps the limit at depth
      room[l]     = (CMP_W'(lvl_count[l]) < CMP_W'(limit)) &&
                    (lvl_count[l] < LC_W'(LEVEL_DEPTH));
      nonempty[l] = (lvl_count[l] != '0);
    end
  end

  // placement of the entry read from staging
  always_comb begin
    place_ok = 1'b0;
    place_lv = mlqs_pkg::LV_RT;
    if (stg_rd.rt && room[mlqs_pkg::LV_RT]) begin
      place_ok = 1'b1;
      place_lv = mlqs_pkg::LV_RT;
    end else if (stg_rd.prio == 3'd1) begin
      place_ok = room[mlqs_pkg::LV_U1];
      place_lv = mlqs_pkg::LV_U1;
    end else if (stg_rd.prio == 3'd2) begin
      place_ok = room[mlqs_pkg::LV_U2];
      place_lv = mlqs_pkg::LV_U2;
    end else if (stg_rd.prio >= 3'd3) begin
      place_ok = room[mlqs_pkg::LV_U3];
      place_lv = mlqs_pkg::LV_U3;
    end
  end

  always_comb begin
    priority if (nonempty[mlqs_pkg::LV_RT]) pop_sel = mlqs_pkg::LV_RT;
    else if (nonempty[mlqs_pkg::LV_U1])     pop_sel = mlqs_pkg::LV_U1;
    else if (nonempty[mlqs_pkg::LV_U2])     pop_sel = mlqs_pkg::LV_U2;
    else                                    pop_sel = mlqs_pkg::LV_U3;
  end

  always_comb begin
    new_prio = in_data.task_priority;
    if (in_data.demote && (new_prio != mlqs_pkg::PRIO_MAX)) begin
      new_prio = new_prio + 3'd1;
    end
    new_entry.id   = in_data.task_id;
    new_entry.rt   = in_data.task_realtime;
    new_entry.prio = new_prio;
  end

  assign stg_we      = (cmd.accept_add && !stg_full) || (cmd.drain_wr && !place_ok);
  assign stg_wr_data = cmd.drain_wr ? stg_rd : new_entry;

  // memories
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_tail] <= stg_wr_data;
    end
    if (cmd.drain_rd) begin
      stg_rd <= stg_mem[stg_head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_wr && place_ok) begin
      lvl_mem[{place_lv, lvl_tail[place_lv]}] <= stg_rd;
    end
    if (cmd.pop_rd) begin
      lvl_rd <= lvl_mem[{pop_sel, lvl_head[pop_sel]}];
    end
  end

  // control state of the FIFOs
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_head   <= '0;
      stg_count  <= '0;
      drain_left <= '0;
      for (int l = 0; l < NL; l++) begin
        lvl_head[l]  <= '0;
        lvl_count[l] <= '0;
      end
    end else begin
      if (cmd.accept_add && !stg_full) begin
        stg_count <= stg_count + 1'b1;
      end
      if (cmd.accept_disp) begin
        drain_left <= stg_count;
      end
      if (cmd.drain_rd) begin
        stg_head  <= stg_head_inc;
        stg_count <= stg_count - 1'b1;
      end
      if (cmd.drain_wr) begin
        drain_left <= drain_left - 1'b1;
        if (place_ok) begin
          lvl_count[place_lv] <= lvl_count[place_lv] + 1'b1;
        end else begin
          stg_count <= stg_count + 1'b1;
        end
      end
      if (cmd.pop_rd && (nonempty != '0)) begin
        lvl_count[pop_sel] <= lvl_count[pop_sel] - 1'b1;
        lvl_head[pop_sel]  <= (lvl_head[pop_sel] == LI_W'(LEVEL_DEPTH - 1)) ?
                              '0 : lvl_head[pop_sel] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= mlqs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept_add || cmd.pop_done || (cmd.pop_rd && (nonempty == '0))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_add) begin
      out_reg        <= '0;
      out_reg.status <= stg_full ? mlqs_pkg::ST_DROPPED : mlqs_pkg::ST_ADDED;
    end else if (cmd.pop_rd && (nonempty == '0)) begin
      out_reg        <= '0;
      out_reg.status <= mlqs_pkg::ST_EMPTY;
    end else if (cmd.pop_done) begin
      out_reg.status       <= mlqs_pkg::ST_DISPATCHED;
      out_reg.out_task_id  <= lvl_rd.id;
      out_reg.out_realtime <= lvl_rd.rt;
      out_reg.out_priority <= lvl_rd.prio;
    end
  end

  assign out_data = out_reg;

  always_comb begin
    sts.stg_empty   = (stg_count == '0);
    sts.drain_last  = (drain_left == SC_W'(1));
    sts.any_level   = (nonempty != '0);
    sts.out_blocked = out_valid && out_stall;
  end

  a_stg_bound : assert property (@(posedge clk) disable iff (rst)
    stg_count <= SC_W'(STAGING_DEPTH))
    else $error("staging count above depth");

  a_lvl_bound : assert property (@(posedge clk) disable iff (rst)
    (lvl_count[0] <= LC_W'(LEVEL_DEPTH)) && (lvl_count[1] <= LC_W'(LEVEL_DEPTH)) &&
    (lvl_count[2] <= LC_W'(LEVEL_DEPTH)) && (lvl_count[3] <= LC_W'(LEVEL_DEPTH)))
    else $error("level count above depth");

  a_no_load_blocked : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(cmd.accept_add || cmd.pop_done))
    else $error("result loaded while output held");

  a_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_reg.status != mlqs_pkg::ST_DISPATCHED)) |->
    (out_reg.out_task_id == '0))
    else $error("non-dispatch result carries an id");

endmodule

// ----- src/multilevel_priority_queue_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_queue_scheduler
// Staging FIFO feeding four level FIFOs (realtime, user 1..3), one result
// per item.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data: add (opcode 0) or dispatch (1).
// Output channel out_valid/out_stall/out_data: one result per item.
// cfg_we/cfg_wdata write the level queue limit (reset 16).
// An add's result is registered: it is valid the cycle after accept.
// A dispatch walks the entries staged at accept time, each with a staging
// memory read, then a placement write, then reads the level memory. One
// item is in work at a time; in_stall is high while a dispatch runs or
// while a result waits on a stalled receiver. The result register holds
// its item until taken.
// Synchronous reset empties all FIFOs (counts and heads to zero) and drops
// any pending result; stored entries are not cleared.
// ----------------------------------------------------------------------------
module multilevel_priority_queue_scheduler #(
  parameter int LEVEL_DEPTH   = mlqs_pkg::LEVEL_DEPTH_DEF,
  parameter int STAGING_DEPTH = mlqs_pkg::STAGING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mlqs_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mlqs_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [mlqs_pkg::LIMIT_W-1:0]  cfg_wdata
);

  mlqs_pkg::cmd_t cmd;
  mlqs_pkg::sts_t sts;

  mlqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_data.opcode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mlqs_dp #(
    .LEVEL_DEPTH   (LEVEL_DEPTH),
    .STAGING_DEPTH (STAGING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule

// ----- tb/multilevel_priority_queue_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_queue_scheduler_tb
// Self-checking bench: a scoreboard model of the staging and level queues
// predicts every result. Directed corner items, limit sweeps and random
// add/dispatch traffic are applied, mostly with random gaps and output stalls.
// ----------------------------------------------------------------------------
module multilevel_priority_queue_scheduler_tb;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mlqs_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mlqs_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [mlqs_pkg::LIMIT_W-1:0] cfg_wdata = '0;

  multilevel_priority_queue_scheduler u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // scheduler state as the bench sees it
  mlqs_pkg::entry_t staged_q[$];
  mlqs_pkg::entry_t level_q[mlqs_pkg::NUM_LEVELS][$];
  int unsigned level_limit = mlqs_pkg::LIMIT_RESET;
  mlqs_pkg::out_t pending_results[$];

  int errors = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_dispatched = 0;
  int n_empty = 0;
  int n_dropped = 0;
  int stuck_adds = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  function automatic bit level_push(int lv, mlqs_pkg::entry_t e);
    int unsigned lim;
    lim = (level_limit > mlqs_pkg::LEVEL_DEPTH_DEF) ? mlqs_pkg::LEVEL_DEPTH_DEF : level_limit;
    if (level_q[lv].size() >= lim) return 1'b0;
    level_q[lv].push_back(e);
    return 1'b1;
  endfunction

  function automatic bit place_task(mlqs_pkg::entry_t e);
    if (e.rt && level_push(mlqs_pkg::LV_RT, e)) return 1'b1;
    if (e.prio == 3'd1) return level_push(mlqs_pkg::LV_U1, e);
    if (e.prio == 3'd2) return level_push(mlqs_pkg::LV_U2, e);
    if (e.prio >= 3'd3) return level_push(mlqs_pkg::LV_U3, e);
    return 1'b0;
  endfunction

  function automatic mlqs_pkg::out_t schedule(mlqs_pkg::in_t d);
    mlqs_pkg::out_t r;
    mlqs_pkg::entry_t e;
    int n;
    r = '0;
    if (d.opcode == mlqs_pkg::OP_ADD) begin
      if (staged_q.size() >= mlqs_pkg::STAGING_DEPTH_DEF) begin
        r.status = mlqs_pkg::ST_DROPPED;
        return r;
      end
      e.id = d.task_id;
      e.rt = d.task_realtime;
      e.prio = (d.demote && d.task_priority != mlqs_pkg::PRIO_MAX) ? d.task_priority + 3'd1
                                                                    : d.task_priority;
      staged_q.push_back(e);
      r.status = mlqs_pkg::ST_ADDED;
      return r;
    end
    n = staged_q.size();
    for (int i = 0; i < n; i++) begin
      e = staged_q.pop_front();
      if (!place_task(e)) staged_q.push_back(e);
    end
    for (int lv = 0; lv < mlqs_pkg::NUM_LEVELS; lv++) begin
      if (level_q[lv].size() != 0) begin
        e = level_q[lv].pop_front();
        r.status = mlqs_pkg::ST_DISPATCHED;
        r.out_task_id = e.id;
        r.out_realtime = e.rt;
        r.out_priority = e.prio;
        return r;
      end
    end
    r.status = mlqs_pkg::ST_EMPTY;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a rising edge; leaves valid high when no gap follows
  task automatic send_item(mlqs_pkg::in_t d);
    int g;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(schedule(d));
    n_items++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v[mlqs_pkg::LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    level_limit = v[mlqs_pkg::LIMIT_W-1:0];
    @(posedge clk);
  endtask

  function automatic mlqs_pkg::in_t make_add(logic [7:0] id, bit rt, logic [2:0] prio,
                                             bit dem);
    mlqs_pkg::in_t d;
    d.opcode = mlqs_pkg::OP_ADD;
    d.task_id = id;
    d.task_realtime = rt;
    d.task_priority = prio;
    d.demote = dem;
    return d;
  endfunction

  function automatic mlqs_pkg::in_t make_dispatch();
    mlqs_pkg::in_t d;
    d = mlqs_pkg::in_t'($urandom);
    d.opcode = mlqs_pkg::OP_DISPATCH;
    return d;
  endfunction

  function automatic mlqs_pkg::in_t rand_item(int add_pct);
    mlqs_pkg::in_t d;
    d = mlqs_pkg::in_t'($urandom);
    d.opcode = ($urandom_range(0, 99) < add_pct) ? mlqs_pkg::OP_ADD : mlqs_pkg::OP_DISPATCH;
    // non-realtime priority 0 stays staged forever, keep it rare
    if (d.opcode == mlqs_pkg::OP_ADD && !d.task_realtime && d.task_priority == 3'd0 &&
        !d.demote) begin
      if (stuck_adds >= 4 || $urandom_range(0, 9) != 0) d.demote = 1'b1;
      else stuck_adds++;
    end
    return d;
  endfunction

  // receiver stall: bursts of random length, mostly short
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      stall_left <= ($urandom_range(0, 99) < 93) ? $urandom_range(0, 3)
                                                 : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    mlqs_pkg::out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status == mlqs_pkg::ST_DISPATCHED) n_dispatched++;
        if (out_data.status == mlqs_pkg::ST_EMPTY) n_empty++;
        if (out_data.status == mlqs_pkg::ST_DROPPED) n_dropped++;
        if (out_data.status !== exp_r.status || out_data.out_task_id !== exp_r.out_task_id ||
            out_data.out_realtime !== exp_r.out_realtime ||
            out_data.out_priority !== exp_r.out_priority) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d id %0d/%0d rt %0d/%0d prio %0d/%0d (exp/act)",
                     exp_r.status, out_data.status, exp_r.out_task_id, out_data.out_task_id,
                     exp_r.out_realtime, out_data.out_realtime,
                     exp_r.out_priority, out_data.out_priority);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("multilevel_priority_queue_scheduler regression: fail");
      $finish;
    end
  end

  task automatic test_corners();
    send_item(make_dispatch());                   // nothing waiting
    send_item(make_add(8'd0, 1'b1, 3'd0, 1'b0));
    send_item(make_add(8'd255, 1'b0, 3'd7, 1'b1)); // demote saturates
    send_item(make_add(8'd17, 1'b0, 3'd6, 1'b1));
    send_item(make_add(8'd33, 1'b0, 3'd1, 1'b0));
    send_item(make_add(8'd34, 1'b0, 3'd2, 1'b0));
    send_item(make_add(8'd35, 1'b0, 3'd3, 1'b0));
    send_item(make_add(8'd36, 1'b0, 3'd0, 1'b1));  // demoted to 1
    send_item(make_add(8'd170, 1'b0, 3'd0, 1'b0)); // stays staged
    send_item(make_add(8'd85, 1'b1, 3'd5, 1'b0));
    repeat (10) send_item(make_dispatch());
    stuck_adds++;
  endtask

  task automatic test_limits();
    // limit zero: everything stays staged until staging is full
    set_limit(0);
    repeat (34) send_item(make_add(8'($urandom), 1'($urandom_range(0, 1)),
                                   3'($urandom_range(1, 7)), 1'($urandom_range(0, 1))));
    send_item(make_dispatch());
    // limit one: realtime overflow falls back to the priority rule
    set_limit(1);
    repeat (40) send_item(make_dispatch());
    set_limit(31);
    repeat (20) send_item(rand_item(60));
    set_limit(16);
    repeat (20) send_item(rand_item(40));
  endtask

  task automatic test_quiet_stream();
    wait_drained();
    quiet = 1'b1;
    repeat (60) send_item(rand_item(55));
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int unsigned limits[6] = '{16, 3, 1, 31, 8, 2};
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      for (int i = 0; i < 250; i++) begin
        send_item(rand_item((ph % 2) ? 45 : 60));
        // sender holds off until the block has caught up
        if (i == 125) wait_drained();
      end
    end
    set_limit(16);
    repeat (60) send_item(rand_item(20));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_limits();
    test_quiet_stream();
    test_random();
    wait_drained();
    repeat (80) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_results.size());
    end
    $display("covered %0d items: %0d dispatches served, %0d found nothing, %0d adds dropped",
             n_items, n_dispatched, n_empty, n_dropped);
    $display("limits swept 0, 1, 2, 3, 8, 16, 31 with gaps and stalls; %0d errors", errors);
    if (errors == 0) begin
      $display("multilevel_priority_queue_scheduler regression: pass");
    end else begin
      $display("multilevel_priority_queue_scheduler regression: fail");
    end
    $finish;
  end

endmodule
